// ----- src/eowpc_pkg.sv -----
// ----------------------------------------------------------------------------
// eowpc_pkg
// Shared types, character codes and column helpers for the space-to-tab
// compressing output unit.
// ----------------------------------------------------------------------------
package eowpc_pkg;

  localparam int unsigned COL_W     = 8;
  localparam int unsigned LINE_W    = 10;
  localparam int unsigned CHAR_W    = 8;
  localparam int unsigned TABS_W    = 5;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DAT_W = 10;
  localparam int unsigned Q_AW      = 2;
  localparam int unsigned Q_DEPTH   = 4;

  localparam logic [COL_W-1:0]  TAB_STOP     = 8'd8;
  localparam logic [COL_W-1:0]  COLUMN_LIMIT = 8'd255;
  localparam logic [LINE_W-1:0] LINES_RESET  = 10'd62;

  localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_SPACE   = 8'h20;
  localparam logic [CHAR_W-1:0] CH_TAB     = 8'h09;

  localparam logic [CFG_IDX_W-1:0] REG_UNFORMATTED    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LINES_PER_PAGE = 1'd1;

  // One accepted printable item or newline, ready to be expanded into runs.
  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic [TABS_W-1:0] tabs;
    logic [COL_W-1:0]  spaces;
    logic              page_full;
  } cmd_t;

  // Next tab stop after a column, one bit wider to hold the carry.
  function automatic logic [COL_W:0] next_stop(input logic [COL_W-1:0] col);
    logic [COL_W-1:0] base;
    base = col & ~(TAB_STOP - 8'd1);
    return {1'b0, base} + {1'b0, TAB_STOP};
  endfunction

  // Clamp a widened column value to the column limit.
  function automatic logic [COL_W-1:0] sat_col(input logic [COL_W:0] col);
    logic [COL_W-1:0] r;
    if (col > {1'b0, COLUMN_LIMIT}) begin
      r = COLUMN_LIMIT;
    end else begin
      r = col[COL_W-1:0];
    end
    return r;
  endfunction

endpackage

// ----- src/eowpc_front.sv -----
// ----------------------------------------------------------------------------
// eowpc_front
// Accepts characters, tracks pending and written columns and the page line
// count, and turns each printing character or newline into one command.
// ----------------------------------------------------------------------------
module eowpc_front (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_wr_en,
  input  logic [eowpc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [eowpc_pkg::CFG_DAT_W-1:0]      cfg_wdata,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [eowpc_pkg::CHAR_W-1:0]         in_ch,
  input  logic                                 q_full,
  output logic                                 q_push,
  output eowpc_pkg::cmd_t                      q_cmd
);

  logic                               unformatted_r;
  logic [eowpc_pkg::LINE_W-1:0]       lines_per_page_r;
  logic [eowpc_pkg::COL_W-1:0]        pend_r, pend_nxt;
  logic [eowpc_pkg::COL_W-1:0]        wrt_r, wrt_nxt;
  logic [eowpc_pkg::LINE_W-1:0]       line_r, line_nxt;

  logic                               accept;
  logic                               is_nl, is_sp, is_tab;
  logic [eowpc_pkg::COL_W:0]          w_stop;
  logic                               use_tabs;
  logic [eowpc_pkg::COL_W-1:0]        w_after;
  logic [eowpc_pkg::COL_W-1:0]        base_col;
  logic [eowpc_pkg::LINE_W-1:0]       line_inc;
  logic                               pf;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  assign is_nl  = (in_ch == eowpc_pkg::CH_NEWLINE);
  assign is_sp  = (in_ch == eowpc_pkg::CH_SPACE);
  assign is_tab = (in_ch == eowpc_pkg::CH_TAB);

  // The tab run only starts when the first stop is reachable and the gap is
  // wider than one space; after that every whole stop up to pending is taken.
  assign w_stop   = eowpc_pkg::next_stop(wrt_r);
  assign use_tabs = !unformatted_r && (w_stop <= {1'b0, pend_r}) &&
                    (({1'b0, wrt_r} + 9'd1) < {1'b0, pend_r});
  assign w_after  = use_tabs ? {pend_r[7:3], 3'b000} : wrt_r;
  assign base_col = (wrt_r >= pend_r) ? wrt_r : pend_r;

  assign line_inc = line_r + 10'd1;
  assign pf       = (line_inc >= lines_per_page_r);

  always_comb begin
    pend_nxt = pend_r;
    wrt_nxt  = wrt_r;
    line_nxt = line_r;
    q_push   = 1'b0;
    q_cmd    = '0;
    q_cmd.ch = in_ch;
    if (accept) begin
      if (is_nl) begin
        pend_nxt        = '0;
        wrt_nxt         = '0;
        line_nxt        = pf ? '0 : line_inc;
        q_push          = 1'b1;
        q_cmd.page_full = pf;
      end else if (is_sp) begin
        pend_nxt = eowpc_pkg::sat_col({1'b0, pend_r} + 9'd1);
      end else if (is_tab) begin
        pend_nxt = eowpc_pkg::sat_col(eowpc_pkg::next_stop(pend_r));
      end else begin
        q_push = 1'b1;
        if (use_tabs) begin
          q_cmd.tabs = pend_r[7:3] - wrt_r[7:3];
        end
        if (w_after < pend_r) begin
          q_cmd.spaces = pend_r - w_after;
        end
        pend_nxt = eowpc_pkg::sat_col({1'b0, pend_r} + 9'd1);
        wrt_nxt  = eowpc_pkg::sat_col({1'b0, base_col} + 9'd1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      unformatted_r    <= 1'b0;
      lines_per_page_r <= eowpc_pkg::LINES_RESET;
      pend_r           <= '0;
      wrt_r            <= '0;
      line_r           <= '0;
    end else begin
      pend_r <= pend_nxt;
      wrt_r  <= wrt_nxt;
      line_r <= line_nxt;
      if (cfg_wr_en) begin
        case (cfg_index)
          eowpc_pkg::REG_UNFORMATTED:    unformatted_r    <= cfg_wdata[0];
          eowpc_pkg::REG_LINES_PER_PAGE: lines_per_page_r <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

`ifndef SYNTHESIS
  // A command always carries a newline, or a character other than a space or tab.
  a_push_kind: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !(q_cmd.ch == eowpc_pkg::CH_SPACE || q_cmd.ch == eowpc_pkg::CH_TAB))
    else $error("space or tab pushed as a command");
  a_pf_nl: assert property (@(posedge clk) disable iff (!rst_n)
    q_push && q_cmd.page_full |-> q_cmd.ch == eowpc_pkg::CH_NEWLINE &&
      q_cmd.tabs == '0 && q_cmd.spaces == '0)
    else $error("page end flagged on a non-newline command");
  a_nl_clears: assert property (@(posedge clk) disable iff (!rst_n)
    accept && is_nl |=> pend_r == '0 && wrt_r == '0)
    else $error("newline did not clear the columns");
`endif

endmodule

// ----- src/eowpc_queue.sv -----
// ----------------------------------------------------------------------------
// eowpc_queue
// Small command queue between the front and the run sequencer.
// ----------------------------------------------------------------------------
module eowpc_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  eowpc_pkg::cmd_t push_cmd,
  output logic            full,
  input  logic            pop,
  output logic            head_valid,
  output eowpc_pkg::cmd_t head_cmd
);

  eowpc_pkg::cmd_t               mem [eowpc_pkg::Q_DEPTH];
  logic [eowpc_pkg::Q_AW-1:0]    wr_ptr_r, rd_ptr_r;
  logic [eowpc_pkg::Q_AW:0]      count_r, count_nxt;
  logic                          do_push, do_pop;

  assign full       = (count_r == (eowpc_pkg::Q_AW+1)'(eowpc_pkg::Q_DEPTH));
  assign head_valid = (count_r != '0);
  assign head_cmd   = mem[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_comb begin
    count_nxt = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= (eowpc_pkg::Q_AW+1)'(eowpc_pkg::Q_DEPTH))
    else $error("queue count beyond depth");
  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_ptr_r - rd_ptr_r) == count_r[eowpc_pkg::Q_AW-1:0])
    else $error("queue pointers disagree with count");
  a_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("push into a full queue");
`endif

endmodule

// ----- src/eowpc_back.sv -----
// ----------------------------------------------------------------------------
// eowpc_back
// Expands each queued command into any tab run, any space run and the character,
// one run per cycle while out_ready holds no run back, into an output register.
// ----------------------------------------------------------------------------
module eowpc_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         head_valid,
  input  eowpc_pkg::cmd_t              head_cmd,
  output logic                         pop,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [eowpc_pkg::CHAR_W-1:0] out_char,
  output logic [eowpc_pkg::COL_W-1:0]  out_repeat_res,
  output logic                         out_last,
  output logic                         out_page_full
);

  logic                         tab_done_r, spc_done_r;
  logic                         out_valid_r;
  logic [eowpc_pkg::CHAR_W-1:0] char_r;
  logic [eowpc_pkg::COL_W-1:0]  rep_r;
  logic                         last_r, pf_r;

  logic                         load;
  logic                         sel_tab, sel_spc;

  assign load    = head_valid && (!out_valid_r || out_ready);
  assign sel_tab = (head_cmd.tabs != '0) && !tab_done_r;
  assign sel_spc = !sel_tab && (head_cmd.spaces != '0) && !spc_done_r;
  assign pop     = load && !sel_tab && !sel_spc;

  always_ff @(posedge clk) begin
    if (load) begin
      if (sel_tab) begin
        char_r <= eowpc_pkg::CH_TAB;
        rep_r  <= {3'b000, head_cmd.tabs};
        last_r <= 1'b0;
        pf_r   <= 1'b0;
      end else if (sel_spc) begin
        char_r <= eowpc_pkg::CH_SPACE;
        rep_r  <= head_cmd.spaces;
        last_r <= 1'b0;
        pf_r   <= 1'b0;
      end else begin
        char_r <= head_cmd.ch;
        rep_r  <= 8'd1;
        last_r <= 1'b1;
        pf_r   <= head_cmd.page_full;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      tab_done_r  <= 1'b0;
      spc_done_r  <= 1'b0;
    end else begin
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (load) begin
        tab_done_r <= sel_tab || (tab_done_r && !pop);
        spc_done_r <= sel_spc || (spc_done_r && !pop);
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_char       = char_r;
  assign out_repeat_res = rep_r;
  assign out_last       = last_r;
  assign out_page_full  = pf_r;

`ifndef SYNTHESIS
  a_mid_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !last_r |-> char_r == eowpc_pkg::CH_TAB ||
      char_r == eowpc_pkg::CH_SPACE)
    else $error("padding run with a character other than tab or space");
  a_pf_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && pf_r |-> last_r && char_r == eowpc_pkg::CH_NEWLINE)
    else $error("page end on a run other than a final newline");
  a_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> rep_r != '0)
    else $error("run with a zero count");
  a_flags_clear: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> !tab_done_r && !spc_done_r)
    else $error("run flags left set after the command finished");
`endif

endmodule

// ----- src/entab_output_with_page_count_unit.sv -----
// ----------------------------------------------------------------------------
// entab_output_with_page_count_unit
// Space-to-tab compressing character emitter with page line counting.
// ----------------------------------------------------------------------------
// The input side takes one character per cycle as long as the four-entry
// command queue has room; spaces and tabs only move the pending column and
// produce no output. Every other character becomes up to three runs (tabs,
// spaces, the character), and the run sequencer writes one run per cycle into
// the output register while out_ready does not hold it; a newline is one run.
// The sustained rate is set by that sequencer. Results stay in order and the
// input keeps flowing while a result waits on out_ready until the queue fills.
module entab_output_with_page_count_unit (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_wr_en,
  input  logic [eowpc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [eowpc_pkg::CFG_DAT_W-1:0]      cfg_wdata,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [eowpc_pkg::CHAR_W-1:0]         in_ch,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [eowpc_pkg::CHAR_W-1:0]         out_char,
  output logic [eowpc_pkg::COL_W-1:0]          out_repeat_res,
  output logic                                 out_last,
  output logic                                 out_page_full
);

  logic            q_full, q_push, q_pop, q_head_valid;
  eowpc_pkg::cmd_t q_cmd, q_head;

  eowpc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_ch     (in_ch),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_cmd     (q_cmd)
  );

  eowpc_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_cmd   (q_cmd),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head_cmd   (q_head)
  );

  eowpc_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .head_valid     (q_head_valid),
    .head_cmd       (q_head),
    .pop            (q_pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_char       (out_char),
    .out_repeat_res (out_repeat_res),
    .out_last       (out_last),
    .out_page_full  (out_page_full)
  );

endmodule
